// ----- sv/mm3_pkg.sv -----
// Package: constants, types and helpers for the MurmurHash3 x64_128 byte hash core.
`default_nettype none
package mm3_pkg;
   localparam int LENGTH_BITS = 32;
   localparam logic [63:0] MUL_A = 64'h87c37b91114253d5;
   localparam logic [63:0] MUL_B = 64'h4cf5ad432745937f;
   localparam logic [63:0] ADD_A = 64'h0000000052dce729;
   localparam logic [63:0] ADD_B = 64'h0000000038495ab5;
   localparam logic [63:0] FIN_A = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FIN_B = 64'hc4ceb9fe1a85ec53;
   localparam int DIGIT_BITS = 4;
   localparam int DIGITS = 64 / DIGIT_BITS;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] p;
   } mul_rsp_type;

   function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] s);
      logic [127:0] d;
      d = {v, v} << s;
      return d[127:64];
   endfunction
endpackage
`default_nettype wire

// ----- sv/mm3_mul.sv -----
// Digit-serial 64x64 modulo 2^64 multiplier, four multiplier bits per cycle.
`default_nettype none
module mm3_mul (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mm3_pkg::mul_req_type req,
   output mm3_pkg::mul_rsp_type      rsp
);
   import mm3_pkg::*;
   logic [63:0] acc_ff, acc_in, a_ff, a_in, b_ff, b_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [67:0] part;

   always_comb begin
      acc_in = acc_ff; a_in = a_ff; b_in = b_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      part = {4'd0, a_ff} * {64'd0, b_ff[DIGIT_BITS-1:0]};
      if (req.start) begin
         acc_in = '0; a_in = req.a; b_in = req.b;
         cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + part[63:0];
         a_in = a_ff << DIGIT_BITS;
         b_in = b_ff >> DIGIT_BITS;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIGITS - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; a_ff <= a_in; b_ff <= b_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.p    = acc_ff;
endmodule
`default_nettype wire

// ----- sv/murmur3_x64_128_byte_hash_core.sv -----
// Top level: MurmurHash3 x64_128 over a byte stream with a digit-serial multiplier.
`default_nettype none
// Usage:
//   req_ channel: one item per handshake. req_tdata[7:0] is the byte, req_tuser
//   is byte_valid, req_tlast ends the message. rsp_ channel delivers one item
//   per message: rsp_tdata[63:0] = h1, [127:64] = h2.
//   csr_wr_en/csr_wr_data write the 64-bit seed; write only while idle.
// Throughput:
//   A byte that does not fill a block or end the message is taken without
//   leaving ST_IDLE. Every mix step goes through one shared multiplier that
//   retires 4 bits of the multiplier operand per cycle. A byte that fills a
//   block costs 4 products plus adds; no further item is taken until the
//   block is mixed. A close costs up to 8 products for the tail and
//   finalizer, after which the result goes to the output register.
//   The sequencer runs these products one after another on the shared
//   multiplier.
// Reset:
//   Synchronous, active high; seed and both halves become zero, no item waits.
// Stall:
//   The result holds in the output register while rsp_tready is low; bytes
//   keep flowing meanwhile, but an item that ends a message waits until the
//   output register is empty.
module murmur3_x64_128_byte_hash_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // byte_value[7:0]
   input  wire logic         req_tuser,   // byte_valid
   input  wire logic         req_tlast,   // last_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // hash_low[63:0], hash_high[127:64]
   input  wire logic         csr_wr_en,
   input  wire logic [63:0]  csr_wr_data
);
   import mm3_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_WAIT = 5'b00100,
      ST_POST = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   // Step codes of the microprogram, started from ST_MUL / ST_POST and stepped on in ST_WAIT.
   localparam logic [4:0] S_B1A = 5'd0, S_B1B = 5'd1, S_B2A = 5'd2, S_B2B = 5'd3,
                          S_M2  = 5'd5,
                          S_T2A = 5'd6, S_T2B = 5'd7, S_T1A = 5'd8, S_T1B = 5'd9,
                          S_F1A = 5'd10, S_F1B = 5'd11, S_F2A = 5'd12, S_F2B = 5'd13,
                          S_END = 5'd14;

   state_type state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic [63:0] seed_ff, seed_in, h1_ff, h1_in, h2_ff, h2_in;
   logic [63:0] b0_ff, b0_in, b1_ff, b1_in, k_ff, k_in;
   logic [3:0]  pos_ff, pos_in, tail_ff, tail_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic        inmsg_ff, inmsg_in, fin_ff, fin_in;
   logic        ov_ff, ov_in;
   logic [127:0] od_ff, od_in;
   mul_req_type mreq;
   mul_rsp_type mrsp;
   logic [63:0] lenx, t1, t2;

   mm3_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   assign req_tready = (state_ff == ST_IDLE) && !(ov_ff && req_tlast);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign lenx = 64'(len_ff);

   // Pick the next step after the one that just completed.
   function automatic logic [4:0] next_step(input logic [4:0] s, input logic [3:0] t);
      logic [4:0] n;
      n = s + 5'd1;
      if (s == S_M2) n = S_END;
      if (s == S_T2B || (s == S_T1A - 5'd1 && t < 4'd9)) n = (t >= 4'd1) ? S_T1A : S_F1A;
      if (s == S_T1B) n = S_F1A;
      return n;
   endfunction

   always_comb begin
      state_in = state_ff; step_in = step_ff; seed_in = seed_ff;
      h1_in = h1_ff; h2_in = h2_ff; b0_in = b0_ff; b1_in = b1_ff; k_in = k_ff;
      pos_in = pos_ff; tail_in = tail_ff; len_in = len_ff; inmsg_in = inmsg_ff;
      fin_in = fin_ff; ov_in = ov_ff; od_in = od_ff;
      mreq = '{start: 1'b0, a: k_ff, b: MUL_A};
      t1 = '0; t2 = '0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      if (csr_wr_en) begin
         seed_in = csr_wr_data;
         if (!inmsg_ff) begin
            h1_in = csr_wr_data; h2_in = csr_wr_data;
         end
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (req_tuser) begin
                  if (!pos_ff[3]) b0_in[pos_ff[2:0]*8 +: 8] = req_tdata;
                  else b1_in[pos_ff[2:0]*8 +: 8] = req_tdata;
                  len_in = len_ff + LENGTH_BITS'(1);
                  inmsg_in = 1'b1;
                  pos_in = pos_ff + 4'd1;
               end
               fin_in = req_tlast;
               if (req_tuser && pos_ff == 4'd15) begin
                  step_in = S_B1A; state_in = ST_MUL;
                  k_in = b0_ff; tail_in = 4'd0;
               end else if (req_tlast) begin
                  tail_in = req_tuser ? pos_ff + 4'd1 : pos_ff;
                  state_in = ST_POST;
                  step_in = ((req_tuser ? pos_ff + 4'd1 : pos_ff) >= 4'd9) ? S_T2A
                          : (((req_tuser ? pos_ff + 4'd1 : pos_ff) >= 4'd1) ? S_T1A : S_F1A);
               end
            end
         end
         ST_POST: begin
            // Set the operand for the first multiply of this step.
            mreq.start = 1'b1;
            case (step_in)
               S_T2A: begin mreq.a = b1_ff; mreq.b = MUL_B; end
               S_T1A: begin mreq.a = b0_ff; mreq.b = MUL_A; end
               S_F1A: begin
                  t1 = (h1_ff ^ lenx) + (h2_ff ^ lenx);
                  t2 = (h2_ff ^ lenx) + t1;
                  h1_in = t1; h2_in = t2;
                  mreq.a = t1 ^ (t1 >> 33); mreq.b = FIN_A;
               end
               default: begin mreq.a = k_ff; mreq.b = MUL_A; end
            endcase
            state_in = ST_WAIT;
         end
         ST_MUL: begin
            mreq.start = 1'b1;
            case (step_ff)
               S_B1A: begin mreq.a = b0_ff; mreq.b = MUL_A; end
               default: begin mreq.a = k_ff; mreq.b = MUL_A; end
            endcase
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mrsp.done) begin
               mreq.start = 1'b1;
               state_in = ST_WAIT;
               step_in = next_step(step_ff, tail_ff);
               case (step_ff)
                  S_B1A: begin mreq.a = rotl(mrsp.p, 6'd31); mreq.b = MUL_B; end
                  S_B1B: begin
                     t1 = rotl(h1_ff ^ mrsp.p, 6'd27) + h2_ff;
                     h1_in = t1; mreq.a = b1_ff; mreq.b = MUL_B;
                  end
                  S_B2A: begin mreq.a = rotl(mrsp.p, 6'd33); mreq.b = MUL_A; end
                  S_B2B: begin
                     h1_in = (h1_ff << 2) + h1_ff + ADD_A;
                     h2_in = rotl(h2_ff ^ mrsp.p, 6'd31);
                     mreq.start = 1'b0; step_in = S_M2; state_in = ST_MUL;
                  end
                  S_T2A: begin mreq.a = rotl(mrsp.p, 6'd33); mreq.b = MUL_A; end
                  S_T2B: begin
                     h2_in = h2_ff ^ mrsp.p; mreq.start = 1'b0; state_in = ST_POST;
                  end
                  S_T1A: begin mreq.a = rotl(mrsp.p, 6'd31); mreq.b = MUL_B; end
                  S_T1B: begin
                     h1_in = h1_ff ^ mrsp.p; mreq.start = 1'b0; state_in = ST_POST;
                  end
                  S_F1A: begin
                     t1 = mrsp.p ^ (mrsp.p >> 33); mreq.a = t1; mreq.b = FIN_B;
                  end
                  S_F1B: begin
                     h1_in = mrsp.p ^ (mrsp.p >> 33);
                     mreq.a = h2_ff ^ (h2_ff >> 33); mreq.b = FIN_A;
                  end
                  S_F2A: begin
                     t2 = mrsp.p ^ (mrsp.p >> 33); mreq.a = t2; mreq.b = FIN_B;
                  end
                  S_F2B: begin
                     t2 = mrsp.p ^ (mrsp.p >> 33);
                     t1 = h1_ff + t2;
                     mreq.start = 1'b0;
                     state_in = ST_OUT; step_in = S_END;
                     h1_in = t1; h2_in = t2 + t1;
                  end
                  default: mreq.start = 1'b0;
               endcase
            end
         end
         ST_OUT: begin
            if (!ov_ff || rsp_tready) begin
               od_in = {h2_ff, h1_ff};
               ov_in = 1'b1;
               h1_in = seed_ff; h2_in = seed_ff;
               b0_in = '0; b1_in = '0; pos_in = '0; len_in = '0;
               inmsg_in = 1'b0; fin_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // Block chain ends here with adds on the last products; no further multiply starts.
      if (state_ff == ST_MUL && step_ff == S_M2) begin
         // Finish the h2 update: add h1, times five, add constant.
         t2 = h2_ff + h1_ff;
         h2_in = (t2 << 2) + t2 + ADD_B;
         mreq.start = 1'b0;
         b0_in = '0; b1_in = '0; pos_in = '0;
         if (fin_ff) begin
            state_in = ST_POST; step_in = S_F1A; tail_in = 4'd0;
         end else state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in; od_ff <= od_in; tail_ff <= tail_in;
      if (reset) begin
         state_ff <= ST_IDLE; step_ff <= S_END; seed_ff <= '0;
         h1_ff <= '0; h2_ff <= '0; pos_ff <= '0; len_ff <= '0;
         inmsg_ff <= 1'b0; fin_ff <= 1'b0; ov_ff <= 1'b0;
         b0_ff <= '0; b1_ff <= '0;
      end else begin
         state_ff <= state_in; step_ff <= step_in; seed_ff <= seed_in;
         h1_ff <= h1_in; h2_ff <= h2_in; pos_ff <= pos_in; len_ff <= len_in;
         inmsg_ff <= inmsg_in; fin_ff <= fin_in; ov_ff <= ov_in;
         b0_ff <= b0_in; b1_ff <= b1_in;
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed under stall");
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      mrsp.done |-> state_ff == ST_WAIT) else $error("product outside wait");
endmodule
`default_nettype wire
